// ===== rtl/load_cell_scale_register_device_core_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the load cell scale register device
// Shared property forms; every use sits in a module that has clk and rst.
// ----------------------------------------------------------------------------
`ifndef LOAD_CELL_SCALE_REGISTER_DEVICE_CORE_ASSERT_SVH
`define LOAD_CELL_SCALE_REGISTER_DEVICE_CORE_ASSERT_SVH

// same-cycle implication
`define LCSRD_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define LCSRD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/lcsrd_pkg.sv =====
// ----------------------------------------------------------------------------
// lcsrd_pkg
// Codes, register map and reset values of the scale register device.
// ----------------------------------------------------------------------------
package lcsrd_pkg;

  localparam int SampleW = 24;
  localparam int WordW   = 32;

  typedef enum logic [1:0] {
    OP_SAMPLE = 2'd0,
    OP_READ   = 2'd1,
    OP_WRITE  = 2'd2,
    OP_UNDEF  = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_UNMAPPED = 2'd1,
    ST_REJECT   = 2'd2
  } status_t;

  // register map, first byte of each group
  localparam logic [7:0] REG_RAW     = 8'h00;
  localparam logic [7:0] REG_WEIGHT  = 8'h10;
  localparam logic [7:0] REG_KEY     = 8'h20;
  localparam logic [7:0] REG_LED     = 8'h30;
  localparam logic [7:0] REG_GAP     = 8'h40;
  localparam logic [7:0] REG_TARE    = 8'h50;
  localparam logic [7:0] REG_BOOT    = 8'hFD;
  localparam logic [7:0] REG_VERSION = 8'hFE;
  localparam logic [7:0] REG_ADDR    = 8'hFF;

  localparam logic [7:0]         VERSION_ID = 8'd1;
  localparam logic [SampleW-1:0] SIGN_FLIP  = 24'h80_0000;
  localparam logic [WordW-1:0]   GAP_RESET  = 32'd26214400;
  localparam logic [6:0]         ADDR_RESET = 7'h26;

endpackage

// ===== rtl/lcsrd_in_if.sv =====
// ----------------------------------------------------------------------------
// lcsrd_in_if
// Request channel: samples, register reads and register writes.
// ----------------------------------------------------------------------------
interface lcsrd_in_if ();
  logic        valid;
  logic        ready;
  logic [1:0]  operation;
  logic [7:0]  register_index;
  logic [2:0]  byte_count;
  logic [7:0]  data_zero;
  logic [7:0]  data_one;
  logic [7:0]  data_two;
  logic [7:0]  data_three;
  logic [23:0] sample_word;
  logic        key_level;

  modport source (
    output valid, operation, register_index, byte_count,
    output data_zero, data_one, data_two, data_three, sample_word, key_level,
    input  ready
  );
  modport sink (
    input  valid, operation, register_index, byte_count,
    input  data_zero, data_one, data_two, data_three, sample_word, key_level,
    output ready
  );
endinterface

// ===== rtl/lcsrd_out_if.sv =====
// ----------------------------------------------------------------------------
// lcsrd_out_if
// Response channel: one byte of read data with status and device outputs.
// ----------------------------------------------------------------------------
interface lcsrd_out_if ();
  logic       valid;
  logic       ready;
  logic [7:0] read_byte;
  logic       last;
  logic [1:0] status;
  logic [7:0] led_red;
  logic [7:0] led_green;
  logic [7:0] led_blue;
  logic [6:0] bus_address;

  modport source (
    output valid, read_byte, last, status, led_red, led_green, led_blue,
    output bus_address,
    input  ready
  );
  modport sink (
    input  valid, read_byte, last, status, led_red, led_green, led_blue,
    input  bus_address,
    output ready
  );
endinterface

// ===== rtl/load_cell_scale_register_device_core.sv =====
// ----------------------------------------------------------------------------
// load_cell_scale_register_device_core
// Scale register device: tare, weight division, register reads and writes.
// ----------------------------------------------------------------------------
//  port  | dir | carries
//  req   | in  | sample, read or write item
//  rsp   | out | one read byte or status per transfer, last marks the end
//
//  Reads are accepted, then give one response transfer per byte (1 to 4 bytes).
//  Writes and tare samples give one response transfer.
//  Weight samples pass accept, delta, divider start, 32 divider steps,
//  quotient capture and the response load; a saturating weight skips the steps.
//  Synchronous reset restores gap 400.0, address 0x26 and a pending tare.
//  A stalled rsp holds the response register; req is taken again once the
//  previous item has loaded its last byte.
// ----------------------------------------------------------------------------
`include "load_cell_scale_register_device_core_assert.svh"

module load_cell_scale_register_device_core import lcsrd_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  lcsrd_in_if.sink    req,
  lcsrd_out_if.source rsp
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_DELTA,
    S_DIVIDE,
    S_EMIT
  } state_t;

  state_t state;

  logic [SampleW-1:0] raw_value;
  logic [SampleW-1:0] tare_offset;
  logic [WordW-1:0]   weight_fixed;
  logic [WordW-1:0]   gap_fixed;
  logic [7:0]         red_level;
  logic [7:0]         green_level;
  logic [7:0]         blue_level;
  logic [6:0]         own_address;
  logic               tare_pending;
  logic               key_last;

  logic [SampleW-1:0] delta;
  logic               div_start;
  logic               div_busy;
  logic               div_done;
  logic [WordW-1:0]   div_quotient;

  logic [WordW-1:0]   emit_word;
  logic [2:0]         emit_cnt;
  status_t            emit_status;

  logic               out_valid;
  logic [7:0]         out_byte;
  logic               out_last;
  status_t            out_status;
  logic [7:0]         out_red;
  logic [7:0]         out_green;
  logic [7:0]         out_blue;
  logic [6:0]         out_addr;

  logic               accept;
  logic               out_free;
  logic [SampleW-1:0] sample_ob;
  logic [7:0]         idx;
  op_t                op;
  logic [7:0]         wr_data [4];
  logic [WordW-1:0]   gap_next;

  logic [WordW-1:0]   rd_word;
  logic [2:0]         rd_cnt;
  status_t            rd_status;
  status_t            wr_status;

  assign req.ready = (state == S_IDLE);
  assign accept    = req.valid && req.ready;
  assign out_free  = !out_valid || rsp.ready;
  assign sample_ob = req.sample_word ^ SIGN_FLIP;
  assign idx       = req.register_index;
  assign op        = op_t'(req.operation);

  assign wr_data[0] = req.data_zero;
  assign wr_data[1] = req.data_one;
  assign wr_data[2] = req.data_two;
  assign wr_data[3] = req.data_three;

  assign rsp.valid       = out_valid;
  assign rsp.read_byte   = out_byte;
  assign rsp.last        = out_last;
  assign rsp.status      = out_status;
  assign rsp.led_red     = out_red;
  assign rsp.led_green   = out_green;
  assign rsp.led_blue    = out_blue;
  assign rsp.bus_address = out_addr;

  lcsrd_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (delta),
    .divisor  (gap_fixed),
    .busy     (div_busy),
    .done     (div_done),
    .quotient (div_quotient)
  );

  // read group decode: any index inside a group returns the whole group
  always_comb begin
    rd_word   = '0;
    rd_cnt    = 3'd1;
    rd_status = ST_OK;
    priority if (idx[7:2] == REG_RAW[7:2]) begin
      rd_word = {8'h00, raw_value};
      rd_cnt  = 3'd4;
    end else if (idx[7:2] == REG_WEIGHT[7:2]) begin
      rd_word = weight_fixed;
      rd_cnt  = 3'd4;
    end else if (idx == REG_KEY) begin
      rd_word = {31'd0, key_last};
    end else if (idx[7:2] == REG_LED[7:2] && idx[1:0] != 2'd3) begin
      rd_word = {8'h00, blue_level, green_level, red_level};
      rd_cnt  = 3'd3;
    end else if (idx[7:2] == REG_GAP[7:2]) begin
      rd_word = gap_fixed;
      rd_cnt  = 3'd4;
    end else if (idx == REG_VERSION) begin
      rd_word = {24'd0, VERSION_ID};
    end else if (idx == REG_ADDR) begin
      rd_word = {25'd0, own_address};
    end else begin
      rd_status = ST_UNMAPPED;
    end
  end

  always_comb begin
    priority if (idx[7:2] == REG_LED[7:2] && idx[1:0] != 2'd3) begin
      wr_status = (req.byte_count >= 3'd1 && req.byte_count <= 3'd3) ? ST_OK : ST_REJECT;
    end else if (idx[7:2] == REG_GAP[7:2]) begin
      wr_status = (req.byte_count >= 3'd1 && req.byte_count <= 3'd4) ? ST_OK : ST_REJECT;
    end else if (idx == REG_ADDR) begin
      wr_status = (req.byte_count == 3'd1 && !req.data_zero[7]) ? ST_OK : ST_REJECT;
    end else if (idx == REG_TARE) begin
      wr_status = (req.byte_count == 3'd1 && req.data_zero != 8'd0) ? ST_OK : ST_REJECT;
    end else if (idx[7:2] == REG_RAW[7:2] || idx[7:2] == REG_WEIGHT[7:2] ||
                 idx == REG_KEY || idx == REG_VERSION || idx == REG_BOOT) begin
      wr_status = ST_REJECT;
    end else begin
      wr_status = ST_UNMAPPED;
    end
  end

  // gap bytes after a write; bytes past byte 3 drop
  always_comb begin
    logic [2:0] slot;
    gap_next = gap_fixed;
    for (int i = 0; i < 4; i++) begin
      slot = {1'b0, idx[1:0]} + 3'(i);
      if (3'(i) < req.byte_count && !slot[2]) begin
        gap_next[8*slot[1:0] +: 8] = wr_data[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    logic [2:0] pos;
    div_start <= !rst && (state == S_DELTA);
    if (rst) begin
      state        <= S_IDLE;
      out_valid    <= 1'b0;
      raw_value    <= '0;
      tare_offset  <= '0;
      weight_fixed <= '0;
      gap_fixed    <= GAP_RESET;
      red_level    <= '0;
      green_level  <= '0;
      blue_level   <= '0;
      own_address  <= ADDR_RESET;
      tare_pending <= 1'b1;
      key_last     <= 1'b1;
    end else begin
      // drop the transfer unless the next byte loads in the same cycle
      if (out_valid && rsp.ready && state != S_EMIT) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            emit_word <= (op == OP_READ) ? rd_word : '0;
            emit_cnt  <= (op == OP_READ) ? rd_cnt : 3'd1;
            state     <= (op == OP_SAMPLE && !tare_pending) ? S_DELTA : S_EMIT;
            unique case (op)
              OP_SAMPLE: begin
                emit_status <= ST_OK;
                if (tare_pending) begin
                  tare_offset <= sample_ob;
                end else begin
                  raw_value <= sample_ob;
                end
                // a pressed key arms a tare for the next sample
                tare_pending <= ~req.key_level;
                key_last     <= req.key_level;
              end
              OP_READ: begin
                emit_status <= rd_status;
              end
              OP_WRITE: begin
                emit_status <= wr_status;
                if (wr_status == ST_OK) begin
                  if (idx[7:2] == REG_LED[7:2]) begin
                    for (int i = 0; i < 4; i++) begin
                      pos = {1'b0, idx[1:0]} + 3'(i);
                      if (3'(i) < req.byte_count) begin
                        unique case (pos)
                          3'd0:    red_level   <= wr_data[i];
                          3'd1:    green_level <= wr_data[i];
                          3'd2:    blue_level  <= wr_data[i];
                          default: ;  // past blue: drop
                        endcase
                      end
                    end
                  end else if (idx[7:2] == REG_GAP[7:2]) begin
                    gap_fixed <= gap_next;
                  end else if (idx == REG_ADDR) begin
                    own_address <= req.data_zero[6:0];
                  end else begin
                    tare_pending <= 1'b1;
                  end
                end
              end
              OP_UNDEF: begin
                emit_status <= ST_REJECT;
              end
              default: ;
            endcase
          end
        end
        S_DELTA: begin
          delta <= (raw_value >= tare_offset) ? raw_value - tare_offset
                                              : tare_offset - raw_value;
          state <= S_DIVIDE;
        end
        S_DIVIDE: begin
          if (div_done) begin
            weight_fixed <= div_quotient;
            state        <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (out_free) begin
            out_valid  <= 1'b1;
            out_byte   <= emit_word[7:0];
            out_last   <= (emit_cnt == 3'd1);
            out_status <= emit_status;
            out_red    <= red_level;
            out_green  <= green_level;
            out_blue   <= blue_level;
            out_addr   <= own_address;
            emit_word  <= emit_word >> 8;
            emit_cnt   <= emit_cnt - 3'd1;
            if (emit_cnt == 3'd1) begin
              state <= S_IDLE;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `LCSRD_ASSERT_NOW(a_done_in_divide, div_done, state == S_DIVIDE,
    "divider finished outside the divide state")
  `LCSRD_ASSERT_NOW(a_emit_count, state == S_EMIT, emit_cnt != 3'd0,
    "emit state with no bytes left")
  `LCSRD_ASSERT_NOW(a_status_last, out_valid && out_status != ST_OK, out_last,
    "error status on a non-final transfer")
  `LCSRD_ASSERT_NOW(a_div_idle, state == S_IDLE, !div_busy,
    "divider busy while idle")

endmodule

// ===== rtl/lcsrd_div.sv =====
// ----------------------------------------------------------------------------
// lcsrd_div
// Bit-serial restoring divider: floor(dividend * 2^32 / divisor), saturating.
// ----------------------------------------------------------------------------
`include "load_cell_scale_register_device_core_assert.svh"

module lcsrd_div import lcsrd_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic [SampleW-1:0] dividend,
  input  logic [WordW-1:0]   divisor,
  output logic               busy,
  output logic               done,
  output logic [WordW-1:0]   quotient
);

  logic [WordW-1:0]   rem;
  logic [WordW-1:0]   divs;
  logic [4:0]         step;
  logic [WordW:0]     shifted;
  logic [WordW+1:0]   trial;
  logic               fits;
  logic [WordW-1:0]   wide_dividend;

  assign wide_dividend = {{(WordW-SampleW){1'b0}}, dividend};
  assign shifted       = {rem, 1'b0};
  assign trial         = {1'b0, shifted} - {2'b00, divs};
  assign fits          = ~trial[WordW+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else if (start) begin
      divs <= divisor;
      // quotient reaches 2^32 exactly when dividend >= divisor
      if (divisor == '0 || wide_dividend >= divisor) begin
        quotient <= '1;
        done     <= 1'b1;
        busy     <= 1'b0;
      end else begin
        rem      <= wide_dividend;
        quotient <= '0;
        step     <= '0;
        done     <= 1'b0;
        busy     <= 1'b1;
      end
    end else if (busy) begin
      rem      <= fits ? trial[WordW-1:0] : shifted[WordW-1:0];
      quotient <= {quotient[WordW-2:0], fits};
      step     <= step + 5'd1;
      busy     <= (step != '1);
      done     <= (step == '1);
    end else begin
      done <= 1'b0;
    end
  end

  `LCSRD_ASSERT_NOW(a_start_free, start, !busy, "divider started while busy")
  `LCSRD_ASSERT_NEXT(a_zero_sat, start && divisor == '0, done && quotient == '1,
    "zero divisor did not saturate")
  `LCSRD_ASSERT_NEXT(a_done_pulse, done, !done, "done held longer than one cycle")

endmodule

// ===== tb/sv/load_cell_scale_register_device_core_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// load_cell_scale_register_device_core_checker
// Watches the request and response channels of the scale register device.
// For each request transfer it updates its own copy of the device state:
// tare offset, raw value, weight division, LED levels, gap and address.
// It queues the response bytes that the request should produce and compares
// every response transfer, field by field, with the oldest queued byte.
// ----------------------------------------------------------------------------
module load_cell_scale_register_device_core_checker import lcsrd_pkg::*; (
  input  logic clk,
  input  logic rst,
  lcsrd_in_if  req,
  lcsrd_out_if rsp,
  output int   errors,
  output int   outstanding,
  output int   responses
);

  typedef struct packed {
    logic [7:0] read_byte;
    logic       last;
    status_t    status;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [6:0] address;
  } rsp_byte_t;

  rsp_byte_t bytes_due[$];
  rsp_byte_t oldest;

  logic [SampleW-1:0] raw_value;
  logic [SampleW-1:0] tare_offset;
  logic [WordW-1:0]   weight;
  logic [WordW-1:0]   gap;
  logic [7:0]         led [3];
  logic [6:0]         address;
  logic               tare_due;
  logic               key_seen;

  // |delta| / gap in Q16.16, saturating on a zero gap or a wide quotient
  function automatic logic [WordW-1:0] scale_weight(logic [SampleW-1:0] delta,
                                                    logic [WordW-1:0] divisor);
    logic [63:0] quotient;
    if (divisor == '0) return '1;
    quotient = {8'd0, delta, 32'd0} / {32'd0, divisor};
    if (quotient[63:32] != '0) return '1;
    return quotient[31:0];
  endfunction

  task automatic queue_byte(logic [7:0] value, logic fin, status_t st);
    rsp_byte_t entry;
    entry.read_byte = value;
    entry.last      = fin;
    entry.status    = st;
    entry.red       = led[0];
    entry.green     = led[1];
    entry.blue      = led[2];
    entry.address   = address;
    bytes_due.push_back(entry);
  endtask

  task automatic queue_word(logic [WordW-1:0] value, int count);
    for (int i = 0; i < count; i++)
      queue_byte(value[8*i +: 8], i == count - 1, ST_OK);
  endtask

  task automatic read_group(logic [7:0] idx);
    if (idx <= REG_RAW + 8'd3) begin
      queue_word({8'd0, raw_value}, 4);
    end else if (idx >= REG_WEIGHT && idx <= REG_WEIGHT + 8'd3) begin
      queue_word(weight, 4);
    end else if (idx == REG_KEY) begin
      queue_word({31'd0, key_seen}, 1);
    end else if (idx >= REG_LED && idx <= REG_LED + 8'd2) begin
      queue_word({8'd0, led[2], led[1], led[0]}, 3);
    end else if (idx >= REG_GAP && idx <= REG_GAP + 8'd3) begin
      queue_word(gap, 4);
    end else if (idx == REG_VERSION) begin
      queue_word({24'd0, VERSION_ID}, 1);
    end else if (idx == REG_ADDR) begin
      queue_word({25'd0, address}, 1);
    end else begin
      queue_byte(8'd0, 1'b1, ST_UNMAPPED);
    end
  endtask

  function automatic status_t apply_write(logic [7:0] idx, int count, logic [31:0] data);
    int pos;
    if (idx >= REG_LED && idx <= REG_LED + 8'd2) begin
      if (count < 1 || count > 3) return ST_REJECT;
      for (int i = 0; i < count; i++) begin
        pos = int'(idx - REG_LED) + i;
        // drop bytes past blue
        if (pos < 3) led[pos] = data[8*i +: 8];
      end
      return ST_OK;
    end
    if (idx >= REG_GAP && idx <= REG_GAP + 8'd3) begin
      if (count < 1 || count > 4) return ST_REJECT;
      for (int i = 0; i < count; i++) begin
        pos = int'(idx - REG_GAP) + i;
        if (pos < 4) gap[8*pos +: 8] = data[8*i +: 8];
      end
      return ST_OK;
    end
    if (idx == REG_ADDR) begin
      if (count != 1 || data[7]) return ST_REJECT;
      address = data[6:0];
      return ST_OK;
    end
    if (idx == REG_TARE) begin
      if (count != 1 || data[7:0] == 8'd0) return ST_REJECT;
      tare_due = 1'b1;
      return ST_OK;
    end
    if (idx <= REG_RAW + 8'd3 || (idx >= REG_WEIGHT && idx <= REG_WEIGHT + 8'd3) ||
        idx == REG_KEY || idx == REG_VERSION || idx == REG_BOOT)
      return ST_REJECT;
    return ST_UNMAPPED;
  endfunction

  task automatic apply_request();
    logic [SampleW-1:0] level;
    logic [SampleW-1:0] delta;
    status_t            st;
    case (op_t'(req.operation))
      OP_SAMPLE: begin
        level = req.sample_word ^ SIGN_FLIP;
        if (tare_due) begin
          tare_offset = level;
          tare_due    = 1'b0;
        end else begin
          raw_value = level;
          delta     = (level >= tare_offset) ? level - tare_offset : tare_offset - level;
          weight    = scale_weight(delta, gap);
        end
        if (!req.key_level) tare_due = 1'b1;
        key_seen = req.key_level;
        queue_byte(8'd0, 1'b1, ST_OK);
      end
      OP_READ: read_group(req.register_index);
      OP_WRITE: begin
        st = apply_write(req.register_index, int'(req.byte_count),
                         {req.data_three, req.data_two, req.data_one, req.data_zero});
        queue_byte(8'd0, 1'b1, st);
      end
      default: queue_byte(8'd0, 1'b1, ST_REJECT);
    endcase
  endtask

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      errors++;
      $display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      raw_value   = '0;
      tare_offset = '0;
      weight      = '0;
      gap         = GAP_RESET;
      for (int i = 0; i < 3; i++) led[i] = 8'd0;
      address     = ADDR_RESET;
      tare_due    = 1'b1;
      key_seen    = 1'b1;
      bytes_due.delete();
    end else begin
      if (req.valid && req.ready) apply_request();
      if (rsp.valid && rsp.ready) begin
        responses++;
        if (bytes_due.size() == 0) begin
          errors++;
          $display("%0t: unexpected response: expected none, actual byte %0h last %0b status %0d",
                   $time, rsp.read_byte, rsp.last, rsp.status);
        end else begin
          oldest = bytes_due.pop_front();
          check_field("read_byte", oldest.read_byte, rsp.read_byte);
          check_field("last", oldest.last, rsp.last);
          check_field("status", oldest.status, rsp.status);
          check_field("led_red", oldest.red, rsp.led_red);
          check_field("led_green", oldest.green, rsp.led_green);
          check_field("led_blue", oldest.blue, rsp.led_blue);
          check_field("bus_address", oldest.address, rsp.bus_address);
        end
      end
    end
    outstanding = bytes_due.size();
  end

endmodule

// ===== tb/sv/load_cell_scale_register_device_core_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// load_cell_scale_register_device_core_tb
// Drives samples, register reads and register writes into the scale device:
// a directed pass over tare, saturation, byte drops and rejected writes,
// then random traffic with idle bursts on both channels and one long
// response hold-off. The checker beside the block predicts and compares.
// ----------------------------------------------------------------------------
module load_cell_scale_register_device_core_tb;
  import lcsrd_pkg::*;

  localparam int RandomItems = 305;
  localparam int CalmItems   = 50;
  localparam int HoldCycles  = 300;
  localparam int CycleLimit  = 200000;

  logic clk;
  logic rst;
  logic calm;
  int   errors;
  int   outstanding;
  int   responses;
  int   items_sent = 0;
  int   cycles = 0;

  lcsrd_in_if  req_ch ();
  lcsrd_out_if rsp_ch ();

  load_cell_scale_register_device_core dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  load_cell_scale_register_device_core_checker rsp_check (
    .clk         (clk),
    .rst         (rst),
    .req         (req_ch),
    .rsp         (rsp_ch),
    .errors      (errors),
    .outstanding (outstanding),
    .responses   (responses)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) cycles <= cycles + 1;

  initial begin
    wait (cycles >= CycleLimit);
    $display("tb: failure");
    $finish;
  end

  // one transfer on the request channel, with an optional idle burst first
  task automatic send_item(op_t op, logic [7:0] idx, logic [2:0] count, logic [31:0] data,
                           logic [23:0] word, logic key);
    @(negedge clk);
    if (!calm && $urandom_range(0, 99) < 30) begin
      req_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(negedge clk);
    end
    req_ch.operation      <= op;
    req_ch.register_index <= idx;
    req_ch.byte_count     <= count;
    req_ch.data_zero      <= data[7:0];
    req_ch.data_one       <= data[15:8];
    req_ch.data_two       <= data[23:16];
    req_ch.data_three     <= data[31:24];
    req_ch.sample_word    <= word;
    req_ch.key_level      <= key;
    req_ch.valid          <= 1'b1;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    items_sent++;
  endtask

  task automatic sample(logic [23:0] word, logic key);
    send_item(OP_SAMPLE, 8'($urandom), 3'($urandom), $urandom, word, key);
  endtask

  task automatic read_reg(logic [7:0] idx);
    send_item(OP_READ, idx, 3'($urandom), $urandom, 24'($urandom), 1'($urandom));
  endtask

  task automatic write_reg(logic [7:0] idx, logic [2:0] count, logic [31:0] data);
    send_item(OP_WRITE, idx, count, data, 24'($urandom), 1'($urandom));
  endtask

  // response side: short random stalls, one long hold-off mid-run
  initial begin : rsp_side
    logic held;
    held = 1'b0;
    rsp_ch.ready = 1'b0;
    wait (!rst);
    forever begin
      @(negedge clk);
      if (!held && items_sent >= 120) begin
        held = 1'b1;
        rsp_ch.ready <= 1'b0;
        repeat (HoldCycles) @(negedge clk);
      end else if (!calm && $urandom_range(0, 99) < 8) begin
        rsp_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 11)) @(negedge clk);
      end
      rsp_ch.ready <= 1'b1;
    end
  end

  initial begin : stimulus
    logic [7:0]  idx;
    logic [2:0]  count;
    logic [31:0] data;
    int          pick;
    req_ch.valid          = 1'b0;
    req_ch.operation      = OP_SAMPLE;
    req_ch.register_index = 8'd0;
    req_ch.byte_count     = 3'd0;
    req_ch.data_zero      = 8'd0;
    req_ch.data_one       = 8'd0;
    req_ch.data_two       = 8'd0;
    req_ch.data_three     = 8'd0;
    req_ch.sample_word    = 24'd0;
    req_ch.key_level      = 1'b1;
    calm = 1'b0;
    rst  = 1'b1;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: reset values, tare, extreme samples, saturation, byte drops
    read_reg(REG_VERSION);
    read_reg(REG_ADDR);
    read_reg(REG_GAP + 8'd2);
    read_reg(REG_KEY);
    sample(24'h00_0000, 1'b1);
    sample(24'h7F_FFFF, 1'b1);
    sample(24'h80_0000, 1'b1);
    read_reg(REG_RAW + 8'd3);
    read_reg(REG_WEIGHT + 8'd1);
    write_reg(REG_GAP, 3'd4, 32'd0);
    sample(24'hFF_FFFF, 1'b1);
    write_reg(REG_GAP, 3'd1, 32'h0000_0001);
    sample(24'h12_3456, 1'b1);
    write_reg(REG_GAP, 3'd4, GAP_RESET);
    write_reg(REG_LED, 3'd3, 32'h0001_80FF);
    write_reg(REG_LED + 8'd2, 3'd3, 32'h00AA_55C3);
    write_reg(REG_LED + 8'd1, 3'd4, $urandom);
    read_reg(REG_LED + 8'd1);
    write_reg(REG_ADDR, 3'd1, 32'h0000_007F);
    write_reg(REG_ADDR, 3'd1, 32'h0000_0080);
    write_reg(REG_ADDR, 3'd2, 32'h0000_0011);
    write_reg(REG_TARE, 3'd1, 32'h0000_0000);
    write_reg(REG_TARE, 3'd1, 32'h0000_0005);
    sample(24'($urandom), 1'b0);
    write_reg(REG_BOOT, 3'd1, $urandom);
    write_reg(REG_RAW, 3'd1, $urandom);
    write_reg(8'h77, 3'd1, $urandom);
    read_reg(8'h77);
    send_item(OP_UNDEF, 8'($urandom), 3'($urandom), $urandom, 24'($urandom), 1'($urandom));

    for (int n = 0; n < RandomItems; n++) begin
      calm = (n >= RandomItems - CalmItems);
      pick = $urandom_range(0, 99);
      if (pick < 38) begin
        sample(24'($urandom), $urandom_range(0, 9) != 0);
      end else if (pick < 70) begin
        case ($urandom_range(0, 7))
          0: idx = REG_RAW + 8'($urandom_range(0, 3));
          1: idx = REG_WEIGHT + 8'($urandom_range(0, 3));
          2: idx = REG_KEY;
          3: idx = REG_LED + 8'($urandom_range(0, 2));
          4: idx = REG_GAP + 8'($urandom_range(0, 3));
          5: idx = REG_VERSION;
          6: idx = REG_ADDR;
          default: idx = 8'($urandom);
        endcase
        read_reg(idx);
      end else if (pick < 97) begin
        data  = $urandom;
        count = ($urandom_range(0, 99) < 85) ? 3'($urandom_range(1, 4))
                                             : 3'($urandom_range(0, 7));
        case ($urandom_range(0, 9))
          0, 1, 2: idx = REG_LED + 8'($urandom_range(0, 2));
          3, 4: idx = REG_GAP + 8'($urandom_range(0, 3));
          5: begin
            idx = REG_ADDR;
            if ($urandom_range(0, 3) != 0) count = 3'd1;
          end
          6: begin
            idx = REG_TARE;
            if ($urandom_range(0, 3) != 0) count = 3'd1;
            if ($urandom_range(0, 3) == 0) data[7:0] = 8'd0;
          end
          7, 8: idx = 8'($urandom);
          default: begin
            case ($urandom_range(0, 3))
              0: idx = REG_WEIGHT + 8'($urandom_range(0, 3));
              1: idx = REG_KEY;
              2: idx = REG_VERSION;
              default: idx = REG_BOOT;
            endcase
          end
        endcase
        write_reg(idx, count, data);
      end else begin
        send_item(OP_UNDEF, 8'($urandom), 3'($urandom), $urandom, 24'($urandom),
                  1'($urandom));
      end
    end

    @(negedge clk);
    req_ch.valid <= 1'b0;
    while (outstanding != 0) @(negedge clk);
    // let a weight division still in flight surface
    repeat (50) @(negedge clk);

    $display("Covered %0d requests and %0d response bytes, with a %0d-cycle response hold-off.",
             items_sent, responses, HoldCycles);
    $display("Included key and register tare, zero and tiny gap, LED and gap byte drops.");
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
